### hw/rtl/ctrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctrq_pkg: shared types and codes of the coalescing task ring queue
// Opcodes, push modes, status codes, the slot memory control group and the
// result group handed from the sequencer to the output register.
// ----------------------------------------------------------------------------
package ctrq_pkg;

	localparam int REF_W = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] MODE_MULTIPLE = 2'd0;
	localparam logic [1:0] MODE_ONCE     = 2'd1;
	localparam logic [1:0] MODE_LAST     = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_DUP   = 2'd3;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_live;
	} ram_ctl_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [REF_W-1:0] popped_ref;
		logic             popped_live;
		logic             wake;
	} result_t;

endpackage : ctrq_pkg
`default_nettype wire

### hw/rtl/ctrq_slot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctrq_slot_ram: slot storage of the ring queue
// One write port and one read port; each word holds a live mark and a task
// reference. Read data is registered.
// ----------------------------------------------------------------------------
module ctrq_slot_ram #(
	parameter int QUEUE_DEPTH = 32,
	parameter int ADDR_W      = 5
) (
	input  wire                        clk,
	input  ctrq_pkg::ram_ctl_t         ctl,
	input  wire  [ADDR_W-1:0]          wr_addr,
	input  wire  [ctrq_pkg::REF_W-1:0] wr_ref,
	input  wire  [ADDR_W-1:0]          rd_addr,
	output logic [ctrq_pkg::REF_W-1:0] rd_ref,
	output logic                       rd_live
);
	import ctrq_pkg::*;

	logic [REF_W:0] mem [QUEUE_DEPTH];
	logic [REF_W:0] rd_word_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= {ctl.wr_live, wr_ref};
		end
		if (ctl.rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	assign rd_live = rd_word_q[REF_W];
	assign rd_ref  = rd_word_q[REF_W-1:0];

endmodule : ctrq_slot_ram
`default_nettype wire

### hw/rtl/ctrq_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctrq_seq: queue sequencer with shared match unit
// Holds the ring pointers, walks the held slots through one compare unit for
// duplicate skip and kill, appends on push and takes the head on pop.
// ----------------------------------------------------------------------------
module ctrq_seq #(
	parameter int QUEUE_DEPTH = 32,
	parameter int ADDR_W      = 5,
	parameter int PTR_W       = 6,
	parameter int CNT_W       = 6
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        opcode,
	input  wire  [ctrq_pkg::REF_W-1:0] task_ref,
	input  wire  [1:0]                 push_mode,
	output ctrq_pkg::ram_ctl_t         ram_ctl,
	output logic [ADDR_W-1:0]          wr_addr,
	output logic [ctrq_pkg::REF_W-1:0] wr_ref,
	output logic [ADDR_W-1:0]          rd_addr,
	input  wire  [ctrq_pkg::REF_W-1:0] rd_ref,
	input  wire                        rd_live,
	input  wire                        out_free,
	output logic                       done,
	output ctrq_pkg::result_t          result,
	output logic [CNT_W-1:0]           occ
);
	import ctrq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	localparam logic [PTR_W:0]  SPAN_L  = (PTR_W+1)'(2 * QUEUE_DEPTH);
	localparam logic [PTR_W:0]  DEPTH_P = (PTR_W+1)'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
		logic [PTR_W:0] w;
		w = {1'b0, p};
		if (w >= DEPTH_P) begin
			w = w - DEPTH_P;
		end
		return w[ADDR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W:0] w;
		w = {1'b0, p} + (PTR_W+1)'(1);
		if (w >= SPAN_L) begin
			w = '0;
		end
		return w[PTR_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] count_of(input logic [PTR_W-1:0] t,
			input logic [PTR_W-1:0] h);
		logic [PTR_W:0] d;
		d = {1'b0, t} - {1'b0, h};
		if (t < h) begin
			d = d + SPAN_L;
		end
		return d[CNT_W-1:0];
	endfunction

	state_t            state_q;
	logic              op_q;
	logic [REF_W-1:0]  ref_q;
	logic [1:0]        mode_q;
	logic [PTR_W-1:0]  head_q, tail_q, rd_ptr_q;
	logic [CNT_W-1:0]  held_q, rd_left_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              dup_q;
	logic [REF_W-1:0]  pref_q;
	logic              plive_q;

	logic              accept;
	logic              issue;
	logic              match;
	logic              kill;
	logic              stop;
	logic              append;
	logic [CNT_W-1:0]  held_now;

	assign held_now = count_of(tail_q, head_q);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	assign match  = vld_s1 && rd_live && (rd_ref == ref_q);
	assign kill   = (state_q == S_SCAN) && (op_q == OP_PUSH) && match
		&& (mode_q == MODE_LAST);
	assign stop   = (state_q == S_SCAN) && vld_s1
		&& ((op_q == OP_POP) || (match && (mode_q != MODE_LAST)));
	assign issue  = (state_q == S_SCAN) && (rd_left_q != '0) && !stop;
	assign append = (state_q == S_FINISH) && out_free && (op_q == OP_PUSH)
		&& !dup_q && (held_q < DEPTH_C);
	assign done   = (state_q == S_FINISH) && out_free;

	assign rd_addr        = slot_of(rd_ptr_q);
	assign ram_ctl.rd_en  = issue;
	assign ram_ctl.wr_en  = kill || append;
	assign ram_ctl.wr_live = append;
	assign wr_addr        = append ? slot_of(tail_q) : addr_s1;
	assign wr_ref         = append ? ref_q : rd_ref;

	always_comb begin
		result.status      = ST_OK;
		result.popped_ref  = '0;
		result.popped_live = 1'b0;
		result.wake        = 1'b0;
		occ                = held_q;
		if (op_q == OP_PUSH) begin
			result.wake = 1'b1;
			if (dup_q) begin
				result.status = ST_DUP;
			end else if (held_q >= DEPTH_C) begin
				result.status = ST_FULL;
			end else begin
				occ = held_q + CNT_W'(1);
			end
		end else begin
			if (held_q == '0) begin
				result.status = ST_EMPTY;
			end else begin
				result.popped_ref  = pref_q;
				result.popped_live = plive_q;
				occ                = held_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			vld_s1    <= 1'b0;
			rd_left_q <= '0;
			dup_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					dup_q  <= 1'b0;
					if (accept) begin
						held_q    <= held_now;
						rd_ptr_q  <= head_q;
						if (opcode == OP_POP) begin
							rd_left_q <= CNT_W'(1);
							state_q   <= (held_now == '0) ? S_FINISH : S_SCAN;
						end else begin
							rd_left_q <= held_now;
							state_q   <= ((push_mode == MODE_MULTIPLE) || (held_now == '0))
								? S_FINISH : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					vld_s1  <= issue;
					addr_s1 <= rd_addr;
					if (issue) begin
						rd_ptr_q  <= ptr_next(rd_ptr_q);
						rd_left_q <= rd_left_q - CNT_W'(1);
					end
					if (stop) begin
						dup_q   <= (op_q == OP_PUSH);
						pref_q  <= rd_ref;
						plive_q <= rd_live;
						state_q <= S_FINISH;
					end else if ((rd_left_q == '0) && vld_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						if (append) begin
							tail_q <= ptr_next(tail_q);
						end
						if ((op_q == OP_POP) && (held_q != '0)) begin
							head_q <= ptr_next(head_q);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			ref_q  <= task_ref;
			mode_q <= push_mode;
		end
	end

endmodule : ctrq_seq
`default_nettype wire

### hw/rtl/coalescing_task_ring_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_task_ring_queue: ring queue of task references with coalescing
// Push appends unless full, skips a live duplicate, or kills live duplicates then
// appends; pop returns the oldest slot with its live mark. One beat in, one
// beat out per operation.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. A push in multiple mode and a pop on
// an empty queue skip the slot scan, a pop reads only the head slot, and a
// push in once or last mode scans the slots held at acceptance: the held
// slots are read one per cycle from the slot memory and checked by a single
// compare unit. A once-mode push stops early at the first live match. A new
// beat is taken while the previous result still waits in the output register.
module coalescing_task_ring_queue #(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 opcode,
	input  wire  [ctrq_pkg::REF_W-1:0]          task_ref,
	input  wire  [1:0]                          push_mode,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [1:0]                          status,
	output logic [ctrq_pkg::REF_W-1:0]          popped_ref,
	output logic                                popped_live,
	output logic                                wake,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]    occupancy
);
	import ctrq_pkg::*;

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH) + 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	ram_ctl_t          ram_ctl;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [REF_W-1:0]  wr_ref, rd_ref;
	logic              rd_live;
	logic              out_free;
	logic              done;
	result_t           result;
	logic [CNT_W-1:0]  occ;
	logic              out_valid_q;
	result_t           res_q;
	logic [CNT_W-1:0]  occ_q;

	ctrq_slot_ram #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ADDR_W     (ADDR_W)
	) u_ram (
		.clk    (clk),
		.ctl    (ram_ctl),
		.wr_addr(wr_addr),
		.wr_ref (wr_ref),
		.rd_addr(rd_addr),
		.rd_ref (rd_ref),
		.rd_live(rd_live)
	);

	ctrq_seq #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ADDR_W     (ADDR_W),
		.PTR_W      (PTR_W),
		.CNT_W      (CNT_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.task_ref (task_ref),
		.push_mode(push_mode),
		.ram_ctl  (ram_ctl),
		.wr_addr  (wr_addr),
		.wr_ref   (wr_ref),
		.rd_addr  (rd_addr),
		.rd_ref   (rd_ref),
		.rd_live  (rd_live),
		.out_free (out_free),
		.done     (done),
		.result   (result),
		.occ      (occ)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= result;
			occ_q <= occ;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign popped_ref  = res_q.popped_ref;
	assign popped_live = res_q.popped_live;
	assign wake        = res_q.wake;
	assign occupancy   = occ_q;

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (popped_ref == '0) && !popped_live)
		else $error("empty pop carries a reference");

	a_wake_push: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wake |-> (status != ST_EMPTY) && (popped_ref == '0) && !popped_live)
		else $error("push beat carries pop data");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= CNT_W'(QUEUE_DEPTH)))
		else $error("occupancy beyond queue depth");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while busy");

endmodule : coalescing_task_ring_queue
`default_nettype wire

### tb/coalescing_task_ring_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_task_ring_queue_tb: self-checking bench for the task ring queue
// Sends push and pop beats through the valid/stall input and keeps a
// behavioral copy of the ring with live marks to predict every result. Each
// output beat is compared in order, field by field. Both sides idle at
// random, and one long output hold-off fills the block up.
// ----------------------------------------------------------------------------
module coalescing_task_ring_queue_tb;
	import ctrq_pkg::*;

	localparam int QDEPTH = 32;
	localparam int PTR_W = $clog2(2 * QDEPTH);
	localparam int OCC_W = $clog2(QDEPTH + 1);
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int IDLE_PCT = 14;
	localparam int HOLD_LEN = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 10;
	localparam logic [REF_W-1:0] KEY_REF = 32'h0BAD_F00D;

	typedef struct {
		logic [1:0]       status;
		logic [REF_W-1:0] popped_ref;
		logic             popped_live;
		logic             wake;
		logic [OCC_W-1:0] occupancy;
	} ring_result_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             opcode = OP_PUSH;
	logic [REF_W-1:0] task_ref = '0;
	logic [1:0]       push_mode = MODE_MULTIPLE;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       status;
	logic [REF_W-1:0] popped_ref;
	logic             popped_live;
	logic             wake;
	logic [OCC_W-1:0] occupancy;

	logic [REF_W-1:0] ring_ref [QDEPTH];
	logic             ring_live [QDEPTH];
	logic [PTR_W-1:0] ring_head = '0;
	logic [PTR_W-1:0] ring_tail = '0;
	ring_result_t     pending_results [$];
	int               mismatch_count = 0;
	bit               idle_en = 1'b1;
	int               hold_reqs = 0;
	int               hold_seen = 0;
	int               hold_left = 0;
	longint           cycle_count = 0;

	coalescing_task_ring_queue #(
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.task_ref(task_ref),
		.push_mode(push_mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.popped_ref(popped_ref),
		.popped_live(popped_live),
		.wake(wake),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < QDEPTH; i++) begin
			ring_ref[i] = '0;
			ring_live[i] = 1'b0;
		end
	end

	function automatic ring_result_t ring_predict(input logic op, input logic [REF_W-1:0] ref_in,
		input logic [1:0] mode);
		ring_result_t res;
		logic [PTR_W-1:0] held_ptr;
		logic [PTR_W-1:0] scan;
		int held;
		int slot;
		bit skip;
		res.status = ST_OK;
		res.popped_ref = '0;
		res.popped_live = 1'b0;
		res.wake = 1'b0;
		held_ptr = ring_tail - ring_head;
		held = int'(held_ptr);
		skip = 1'b0;
		if (op == OP_PUSH) begin
			res.wake = 1'b1;
			if (mode != MODE_MULTIPLE) begin
				scan = ring_head;
				for (int k = 0; k < held && !skip; k++) begin
					slot = scan % QDEPTH;
					if (ring_live[slot] && ring_ref[slot] == ref_in) begin
						if (mode == MODE_LAST)
							ring_live[slot] = 1'b0;
						else
							skip = 1'b1;
					end
					scan = scan + 1'b1;
				end
			end
			if (skip) begin
				res.status = ST_DUP;
			end else if (held >= QDEPTH) begin
				res.status = ST_FULL;
			end else begin
				slot = ring_tail % QDEPTH;
				ring_ref[slot] = ref_in;
				ring_live[slot] = 1'b1;
				ring_tail = ring_tail + 1'b1;
			end
		end else if (held == 0) begin
			res.status = ST_EMPTY;
		end else begin
			slot = ring_head % QDEPTH;
			res.popped_ref = ring_ref[slot];
			res.popped_live = ring_live[slot];
			ring_live[slot] = 1'b0;
			ring_head = ring_head + 1'b1;
		end
		held_ptr = ring_tail - ring_head;
		res.occupancy = held_ptr;
		return res;
	endfunction

	task automatic send_beat(input logic op, input logic [REF_W-1:0] ref_in,
		input logic [1:0] mode);
		while (idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		task_ref <= ref_in;
		push_mode <= mode;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(ring_predict(op, ref_in, mode));
	endtask

	task automatic send_random_op(input int pop_pct);
		logic op;
		logic [REF_W-1:0] pick;
		logic [1:0] mode;
		op = ($urandom_range(99) < pop_pct) ? OP_POP : OP_PUSH;
		pick = $urandom;
		if ($urandom_range(99) < 70) begin
			case ($urandom_range(5))
				0: pick = '0;
				1: pick = '1;
				2: pick = 32'h8000_0000;
				3: pick = 32'h7FFF_FFFF;
				4: pick = 32'h5A5A_5A5A;
				default: pick = 32'hA5A5_A5A5;
			endcase
		end
		mode = ($urandom_range(9) == 0) ? MODE_SPARE : 2'($urandom_range(2));
		send_beat(op, pick, mode);
	endtask

	task automatic test_pop_empty();
		send_beat(OP_POP, $urandom, 2'($urandom_range(3)));
	endtask

	task automatic test_push_modes();
		send_beat(OP_PUSH, 32'h0000_0000, MODE_MULTIPLE);
		send_beat(OP_PUSH, 32'hFFFF_FFFF, MODE_MULTIPLE);
		send_beat(OP_PUSH, 32'h0000_0000, MODE_ONCE);
		send_beat(OP_PUSH, 32'hFFFF_FFFF, MODE_SPARE);
		send_beat(OP_PUSH, 32'h0000_0000, MODE_LAST);
		send_beat(OP_PUSH, 32'h5A5A_5A5A, MODE_ONCE);
		repeat (5) send_beat(OP_POP, $urandom, 2'($urandom_range(3)));
	endtask

	task automatic test_full_queue();
		for (int i = 0; i < QDEPTH; i++)
			send_beat(OP_PUSH, (i == 1) ? KEY_REF : (32'hC000_0000 | i), MODE_MULTIPLE);
		send_beat(OP_PUSH, $urandom, MODE_MULTIPLE);
		send_beat(OP_PUSH, KEY_REF, MODE_ONCE);
		send_beat(OP_PUSH, KEY_REF, MODE_LAST);
		send_beat(OP_POP, $urandom, MODE_MULTIPLE);
		// killed copy must not match
		send_beat(OP_PUSH, KEY_REF, MODE_ONCE);
		repeat (QDEPTH) send_beat(OP_POP, $urandom, 2'($urandom_range(3)));
	endtask

	task automatic test_random_traffic();
		int pop_pct;
		for (int phase = 0; phase < 13; phase++) begin
			pop_pct = (phase % 3 == 0) ? 25 : (phase % 3 == 1) ? 50 : 72;
			idle_en = !(phase == 6 || phase == 7);
			repeat (100) send_random_op(pop_pct);
		end
		idle_en = 1'b1;
	endtask

	task automatic test_output_hold();
		idle_en = 1'b0;
		hold_reqs <= hold_reqs + 1;
		repeat (80) send_random_op(35);
		idle_en = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_LEN - 1;
			hold_seen <= hold_seen + 1;
		end else begin
			out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin : check_results
		ring_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result beat at cycle %0d: status %0d ref %h",
						cycle_count, status, popped_ref);
			end else begin
				want = pending_results.pop_front();
				if (want.status !== status || want.popped_ref !== popped_ref ||
					want.popped_live !== popped_live || want.wake !== wake ||
					want.occupancy !== occupancy) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("mismatch at cycle %0d: expected status %0d ref %h live %b wake %b occ %0d",
							cycle_count, want.status, want.popped_ref, want.popped_live,
							want.wake, want.occupancy);
						$display("  got status %0d ref %h live %b wake %b occ %0d",
							status, popped_ref, popped_live, wake, occupancy);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL coalescing_task_ring_queue");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pop_empty();
		test_push_modes();
		test_full_queue();
		test_random_traffic();
		test_output_hold();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4 * (QDEPTH + 3)) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS coalescing_task_ring_queue");
		else
			$display("FAIL coalescing_task_ring_queue");
		$finish;
	end

endmodule
